/* src/xsrng_pkg.sv */
package xsrng_pkg;

  localparam logic [63:0] GOLDEN_STEP = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] MIX_MUL_A   = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] MIX_MUL_B   = 64'h94d0_49bb_1331_11eb;

  localparam int UPC_W = 5;
  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [1:0] {
    CMD_RESEED,
    CMD_RAW,
    CMD_BOUNDED,
    CMD_UNUSED
  } cmd_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_SEED_LOAD,
    OP_SM_ADD,
    OP_XS30,
    OP_XS27,
    OP_MUL0,
    OP_MUL1,
    OP_MUL2,
    OP_SM_STORE,
    OP_NEXT1,
    OP_NEXT2,
    OP_DIV_LOAD_THR,
    OP_DIV_LOAD_VAL,
    OP_DIV_STEP,
    OP_SET_THR,
    OP_EMIT_ZERO,
    OP_EMIT_ERR,
    OP_EMIT_RAW,
    OP_EMIT_REM
  } op_t;

  typedef enum logic [2:0] {
    JMP_NONE,
    JMP_WIDX,
    JMP_CNT,
    JMP_BELOW,
    JMP_ZERO
  } cond_t;

  typedef struct packed {
    op_t   op;
    logic  mul_b;
    cond_t cond;
    upc_t  target;
    logic  last;
  } uword_t;

  // program entry points and branch targets
  localparam upc_t PC_RESEED   = 5'd0;
  localparam upc_t PC_SM_LOOP  = 5'd1;
  localparam upc_t PC_ZERO_END = 5'd11;
  localparam upc_t PC_RAW      = 5'd12;
  localparam upc_t PC_BOUNDED  = 5'd15;
  localparam upc_t PC_DIV_THR  = 5'd16;
  localparam upc_t PC_DRAW     = 5'd18;
  localparam upc_t PC_DIV_VAL  = 5'd22;
  localparam upc_t PC_ERR      = 5'd24;

  function automatic uword_t ucode(upc_t pc);
    uword_t w;
    unique case (pc)
      5'd0:    w = '{OP_SEED_LOAD,    1'b0, JMP_NONE,  PC_RESEED,  1'b0};
      5'd1:    w = '{OP_SM_ADD,       1'b0, JMP_NONE,  PC_RESEED,  1'b0};
      5'd2:    w = '{OP_XS30,         1'b0, JMP_NONE,  PC_RESEED,  1'b0};
      5'd3:    w = '{OP_MUL0,         1'b0, JMP_NONE,  PC_RESEED,  1'b0};
      5'd4:    w = '{OP_MUL1,         1'b0, JMP_NONE,  PC_RESEED,  1'b0};
      5'd5:    w = '{OP_MUL2,         1'b0, JMP_NONE,  PC_RESEED,  1'b0};
      5'd6:    w = '{OP_XS27,         1'b0, JMP_NONE,  PC_RESEED,  1'b0};
      5'd7:    w = '{OP_MUL0,         1'b1, JMP_NONE,  PC_RESEED,  1'b0};
      5'd8:    w = '{OP_MUL1,         1'b1, JMP_NONE,  PC_RESEED,  1'b0};
      5'd9:    w = '{OP_MUL2,         1'b1, JMP_NONE,  PC_RESEED,  1'b0};
      5'd10:   w = '{OP_SM_STORE,     1'b0, JMP_WIDX,  PC_SM_LOOP, 1'b0};
      5'd11:   w = '{OP_EMIT_ZERO,    1'b0, JMP_NONE,  PC_RESEED,  1'b1};
      5'd12:   w = '{OP_NEXT1,        1'b0, JMP_NONE,  PC_RESEED,  1'b0};
      5'd13:   w = '{OP_NEXT2,        1'b0, JMP_NONE,  PC_RESEED,  1'b0};
      5'd14:   w = '{OP_EMIT_RAW,     1'b0, JMP_NONE,  PC_RESEED,  1'b1};
      5'd15:   w = '{OP_DIV_LOAD_THR, 1'b0, JMP_ZERO,  PC_ERR,     1'b0};
      5'd16:   w = '{OP_DIV_STEP,     1'b0, JMP_CNT,   PC_DIV_THR, 1'b0};
      5'd17:   w = '{OP_SET_THR,      1'b0, JMP_NONE,  PC_RESEED,  1'b0};
      5'd18:   w = '{OP_NEXT1,        1'b0, JMP_NONE,  PC_RESEED,  1'b0};
      5'd19:   w = '{OP_NEXT2,        1'b0, JMP_NONE,  PC_RESEED,  1'b0};
      5'd20:   w = '{OP_NOP,          1'b0, JMP_BELOW, PC_DRAW,    1'b0};
      5'd21:   w = '{OP_DIV_LOAD_VAL, 1'b0, JMP_NONE,  PC_RESEED,  1'b0};
      5'd22:   w = '{OP_DIV_STEP,     1'b0, JMP_CNT,   PC_DIV_VAL, 1'b0};
      5'd23:   w = '{OP_EMIT_REM,     1'b0, JMP_NONE,  PC_RESEED,  1'b1};
      5'd24:   w = '{OP_EMIT_ERR,     1'b0, JMP_NONE,  PC_RESEED,  1'b1};
      default: w = '{OP_EMIT_ZERO,    1'b0, JMP_NONE,  PC_RESEED,  1'b1};
    endcase
    return w;
  endfunction

endpackage

/* src/xoshiro256ss_bounded_rng_unit.sv */
// xoshiro256** generator with splitmix64 seeding and unbiased bounded draws.
// Input channel (s_*): one transfer is one command. s_tuser carries the
// command (reseed, raw draw, bounded draw), s_tdata the bound n.
// Output channel (m_*): one transfer per command. m_tdata is the value, m_tuser
// the status (1: bounded draw with n == 0 rejected, value zero).
// seed_we / seed_wdata load the seed register; only a reseed command uses it.
// Commands run one at a time through a microcoded sequencer with one shared
// 32x32 multiplier and a one-bit-per-cycle restoring divider. A bounded draw
// runs two 64-step modulo passes, one for the rejection threshold and one on
// the accepted draw, plus one draw per attempt; a zero bound is rejected first.
// A reseed runs four splitmix64 rounds of ten steps each, the two
// 64-bit constant multiplies costing three partial-product steps each.
// Reset runs the reseed program on seed zero; s_tready stays low while it
// runs and no result is produced. The result sits in an output register, so
// the next command is taken while it waits; a command finishing while that
// register is still full and m_tready is low waits on its last step.
module xoshiro256ss_bounded_rng_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_we,
  input  logic [63:0] seed_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] bound
  input  logic [1:0]  s_tuser,   // [1:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [63:0] value
  output logic [0:0]  m_tuser    // [0] status
);
  import xsrng_pkg::*;

  logic        busy;
  logic        init;
  upc_t        pc;
  logic [63:0] seed_value;

  logic [63:0] s [4];
  logic [63:0] seed_run;
  logic [63:0] z;
  logic [63:0] mp;
  logic [31:0] mh;
  logic [1:0]  widx;
  logic [63:0] nreg;
  logic [63:0] dq;
  logic [63:0] rem;
  logic [5:0]  cnt;
  logic [63:0] thr;
  logic [63:0] out_value;
  logic        out_status;

  uword_t      uw;
  logic        accept;
  logic        stall;
  logic        exec;
  logic        jump;
  upc_t        entry;
  logic [63:0] mconst;
  logic [31:0] mx;
  logic [31:0] my;
  logic [63:0] mul_out;
  logic [31:0] hi_sum;
  logic [64:0] trial;
  logic [64:0] trial_sub;
  logic        fits;
  logic [63:0] s1x5;
  logic [63:0] rot7;
  logic [63:0] s2a;
  logic [63:0] s3a;

  assign uw       = ucode(pc);
  assign s_tready = !busy;
  assign accept   = s_tvalid && !busy;
  assign stall    = uw.last && m_tvalid && !m_tready && !init;
  assign exec     = busy && !stall;
  assign m_tdata  = out_value;
  assign m_tuser  = out_status;

  always_comb begin
    unique case (cmd_t'(s_tuser))
      CMD_RESEED:  entry = PC_RESEED;
      CMD_RAW:     entry = PC_RAW;
      CMD_BOUNDED: entry = PC_BOUNDED;
      CMD_UNUSED:  entry = PC_ZERO_END;
      default:     entry = PC_ZERO_END;
    endcase
  end

  always_comb begin
    unique case (uw.cond)
      JMP_NONE:  jump = 1'b0;
      JMP_WIDX:  jump = (widx != '1);
      JMP_CNT:   jump = (cnt != '1);
      JMP_BELOW: jump = (z < thr);
      JMP_ZERO:  jump = (nreg == '0);
      default:   jump = 1'b0;
    endcase
  end

  // shared multiplier: low 64 bits of z * constant in three partial products
  assign mconst = uw.mul_b ? MIX_MUL_B : MIX_MUL_A;
  always_comb begin
    mx = z[63:32];
    my = mconst[31:0];
    if (uw.op == OP_MUL0) begin
      mx = z[31:0];
    end else if (uw.op == OP_MUL1) begin
      mx = z[31:0];
      my = mconst[63:32];
    end
  end
  assign mul_out = {32'd0, mx} * {32'd0, my};
  assign hi_sum  = mp[63:32] + mh + mul_out[31:0];

  assign trial     = {rem, dq[63]};
  assign trial_sub = trial - {1'b0, nreg};
  assign fits      = (trial >= {1'b0, nreg});

  assign s1x5 = s[1] + {s[1][61:0], 2'b00};
  assign rot7 = {z[56:0], z[63:57]};
  assign s2a  = s[2] ^ s[0];
  assign s3a  = s[3] ^ s[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b1;
      init       <= 1'b1;
      pc         <= PC_RESEED;
      m_tvalid   <= 1'b0;
      seed_value <= '0;
    end else begin
      if (seed_we) begin
        seed_value <= seed_wdata;
      end
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept) begin
        busy <= 1'b1;
        pc   <= entry;
      end else if (exec) begin
        if (uw.last) begin
          busy <= 1'b0;
          init <= 1'b0;
          if (!init) begin
            m_tvalid <= 1'b1;
          end
        end else if (jump) begin
          pc <= uw.target;
        end else begin
          pc <= pc + upc_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      nreg <= s_tdata;
    end
    if (exec) begin
      unique case (uw.op)
        OP_SEED_LOAD: begin
          seed_run <= init ? '0 : seed_value;
          widx     <= '0;
        end
        OP_SM_ADD: begin
          seed_run <= seed_run + GOLDEN_STEP;
          z        <= seed_run + GOLDEN_STEP;
        end
        OP_XS30: z <= z ^ (z >> 30);
        OP_XS27: z <= z ^ (z >> 27);
        OP_MUL0: mp <= mul_out;
        OP_MUL1: mh <= mul_out[31:0];
        OP_MUL2: z <= {hi_sum, mp[31:0]};
        OP_SM_STORE: begin
          s[widx] <= z ^ (z >> 31);
          widx    <= widx + 2'd1;
        end
        OP_NEXT1: begin
          z    <= s1x5;
          s[0] <= s[0] ^ s3a;
          s[1] <= s[1] ^ s2a;
          s[2] <= s2a ^ {s[1][46:0], 17'b0};
          s[3] <= {s3a[18:0], s3a[63:19]};
        end
        OP_NEXT2: z <= rot7 + {rot7[60:0], 3'b000};
        OP_DIV_LOAD_THR: begin
          dq  <= '0 - nreg;
          rem <= '0;
          cnt <= '0;
        end
        OP_DIV_LOAD_VAL: begin
          dq  <= z;
          rem <= '0;
          cnt <= '0;
        end
        OP_DIV_STEP: begin
          rem <= fits ? trial_sub[63:0] : trial[63:0];
          dq  <= {dq[62:0], 1'b0};
          cnt <= cnt + 6'd1;
        end
        OP_SET_THR: thr <= rem;
        OP_EMIT_ZERO: begin
          out_value  <= '0;
          out_status <= 1'b0;
        end
        OP_EMIT_ERR: begin
          out_value  <= '0;
          out_status <= 1'b1;
        end
        OP_EMIT_RAW: begin
          out_value  <= z;
          out_status <= 1'b0;
        end
        OP_EMIT_REM: begin
          out_value  <= rem;
          out_status <= 1'b0;
        end
        OP_NOP: ;
        default: ;
      endcase
    end
  end

endmodule

/* src/xsrng_checker.sv */
module xsrng_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [63:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // held result must not change until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // a rejected bound always reports a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == 64'd0)
    else $error("error status with nonzero value");

  // one command at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second command accepted without a gap");

  // reset seeding produces no result
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind xoshiro256ss_bounded_rng_unit xsrng_checker u_xsrng_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
